// File: design/lss_pkg.sv
// lss_pkg: shared constants, codes and state type for the lottery scheduler select block
// no dependencies; imported by lss_div, lottery_scheduler_select, the checker and the testbench
`timescale 1ns / 1ps
`default_nettype none

package lss_pkg;

  // table size and derived widths
  localparam int MaxProcs = 16;
  localparam int CntW     = $clog2(MaxProcs + 1);
  localparam int IdxW     = (MaxProcs > 1) ? $clog2(MaxProcs) : 1;

  // field widths
  localparam int IdW      = 16;
  localparam int TktW     = 16;
  localparam int DrawW    = 7;
  localparam int StatW    = 2;
  localparam int ReqW     = 2;

  // percent scaling
  localparam int Scale    = 100;
  localparam int ScaleW   = $clog2(Scale + 1);
  // quotient never exceeds the scale since one entry is at most the total
  localparam int QuoW     = ScaleW;
  localparam int TotW     = TktW + CntW;
  localparam int ProdW    = TktW + ScaleW;
  localparam int DsW      = TotW + QuoW;
  localparam int StepW    = (QuoW > 1) ? $clog2(QuoW) : 1;

  // request codes
  localparam logic [ReqW-1:0] ReqAdd  = 2'd0;
  localparam logic [ReqW-1:0] ReqNorm = 2'd1;
  localparam logic [ReqW-1:0] ReqDraw = 2'd2;
  localparam logic [ReqW-1:0] ReqNone = 2'd3;

  // status codes
  localparam logic [StatW-1:0] StOk       = 2'd0;
  localparam logic [StatW-1:0] StNoWinner = 2'd1;
  localparam logic [StatW-1:0] StFull     = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SUM,
    S_DIV_GO,
    S_DIV_WAIT,
    S_DRAW,
    S_DONE
  } seq_state_t;

endpackage : lss_pkg

`default_nettype wire

// File: design/lss_div.sv
// lss_div: restoring divider, one quotient bit per cycle
// depends on lss_pkg for widths
`timescale 1ns / 1ps
`default_nettype none

module lss_div import lss_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [ProdW-1:0] dividend,
  input  wire logic [TotW-1:0]  divisor,
  output logic                  done,
  output logic [QuoW-1:0]       quotient
);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [StepW-1:0] step_r, step_nxt;
  logic [DsW-1:0]   rem_r, rem_nxt;
  logic [DsW-1:0]   dsh_r, dsh_nxt;
  logic [QuoW-1:0]  quo_r, quo_nxt;
  logic             fits;

  assign fits = (rem_r >= dsh_r);

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    rem_nxt  = rem_r;
    dsh_nxt  = dsh_r;
    quo_nxt  = quo_r;
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = StepW'(QuoW - 1);
      rem_nxt  = DsW'(dividend);
      dsh_nxt  = DsW'(divisor) << (QuoW - 1);
      quo_nxt  = '0;
    end else if (busy_r) begin
      if (fits) begin
        rem_nxt = rem_r - dsh_r;
      end
      quo_nxt  = {quo_r[QuoW-2:0], fits};
      dsh_nxt  = dsh_r >> 1;
      step_nxt = step_r - StepW'(1);
      if (step_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    step_r <= step_nxt;
    rem_r  <= rem_nxt;
    dsh_r  <= dsh_nxt;
    quo_r  <= quo_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule : lss_div

`default_nettype wire

// File: design/lottery_scheduler_select.sv
// lottery scheduler select: table of ids and tickets with add, normalize and draw
// sequence: add and unused code go straight to the result; draw walks up to N entries, one per cycle;
// normalize runs a sum pass, then one divide of QuoW steps per entry
// one divider is shared by all entries; one item is worked at a time
// in_stall is high while an item is in work; a finished result waits in the output register
// synchronous active-low reset clears the sequencer, entry count and output valid, not the tables
`timescale 1ns / 1ps
`default_nettype none

module lottery_scheduler_select import lss_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  // input channel
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire logic [ReqW-1:0]  in_req_type,
  input  wire logic [IdW-1:0]   in_process_id,
  input  wire logic [TktW-1:0]  in_ticket_count,
  input  wire logic [DrawW-1:0] in_draw_value,
  // result channel
  output logic                  out_valid,
  input  wire logic             out_stall,
  output logic [StatW-1:0]      out_status,
  output logic [IdW-1:0]        out_winner_id
);

  // entry storage, written at one address and read at the walk index
  logic [IdW-1:0]  id_table   [MaxProcs];
  logic [TktW-1:0] ticket_table [MaxProcs];

  // sequencer state
  seq_state_t       state_r, state_nxt;
  logic [CntW-1:0]  count_r, count_nxt;
  logic [CntW-1:0]  idx_r, idx_nxt;
  logic [TotW-1:0]  total_r, total_nxt;
  logic [DrawW-1:0] draw_r, draw_nxt;
  logic [StatW-1:0] res_status_r, res_status_nxt;
  logic [IdW-1:0]   res_winner_r, res_winner_nxt;

  // output register
  logic             out_valid_r, out_valid_nxt;
  logic [StatW-1:0] out_status_r, out_status_nxt;
  logic [IdW-1:0]   out_winner_r, out_winner_nxt;

  // table write port
  logic             tbl_we;
  logic             tbl_id_we;
  logic [IdxW-1:0]  tbl_waddr;
  logic [TktW-1:0]  tbl_wtkt;

  // walk read and helpers
  logic [TktW-1:0]  cur_tkt;
  logic [TotW-1:0]  run_sum;
  logic [CntW-1:0]  idx_inc;
  logic             last_entry;
  logic             in_beat;
  logic             out_free;

  // divider hookup
  logic             div_start;
  logic             div_done;
  logic [ProdW-1:0] div_dividend;
  logic [QuoW-1:0]  div_quotient;

  assign in_beat    = in_valid && !in_stall;
  assign out_free   = !out_valid_r || !out_stall;
  assign cur_tkt    = ticket_table[idx_r[IdxW-1:0]];
  assign run_sum    = total_r + TotW'(cur_tkt);
  assign idx_inc    = idx_r + CntW'(1);
  assign last_entry = (idx_inc == count_r);
  // tickets times the percent scale, then divided by the total
  assign div_dividend = ProdW'(cur_tkt) * ProdW'(Scale);

  lss_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (total_r),
    .done     (div_done),
    .quotient (div_quotient)
  );

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    idx_nxt        = idx_r;
    total_nxt      = total_r;
    draw_nxt       = draw_r;
    res_status_nxt = res_status_r;
    res_winner_nxt = res_winner_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_status_nxt = out_status_r;
    out_winner_nxt = out_winner_r;
    tbl_we         = 1'b0;
    tbl_id_we      = 1'b0;
    tbl_waddr      = idx_r[IdxW-1:0];
    tbl_wtkt       = '0;
    div_start      = 1'b0;
    in_stall       = (state_r != S_IDLE);

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          idx_nxt        = '0;
          total_nxt      = '0;
          draw_nxt       = in_draw_value;
          res_status_nxt = StOk;
          res_winner_nxt = '0;
          state_nxt      = S_DONE;
          unique case (in_req_type)
            ReqAdd: begin
              if (count_r == CntW'(MaxProcs)) begin
                res_status_nxt = StFull;
              end else begin
                // append at the fill point
                tbl_we    = 1'b1;
                tbl_id_we = 1'b1;
                tbl_waddr = count_r[IdxW-1:0];
                tbl_wtkt  = in_ticket_count;
                count_nxt = count_r + CntW'(1);
              end
            end
            ReqNorm: begin
              if (count_r != '0) begin
                state_nxt = S_SUM;
              end
            end
            ReqDraw: begin
              if (count_r == '0) begin
                res_status_nxt = StNoWinner;
              end else begin
                state_nxt = S_DRAW;
              end
            end
            ReqNone: begin
              state_nxt = S_DONE;
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end

      // first pass: ticket total
      S_SUM: begin
        total_nxt = run_sum;
        if (last_entry) begin
          idx_nxt   = '0;
          state_nxt = S_DIV_GO;
        end else begin
          idx_nxt = idx_inc;
        end
      end

      // second pass: one divide per entry, zero total gives zero shares
      S_DIV_GO: begin
        if (total_r == '0) begin
          tbl_we = 1'b1;
          if (last_entry) begin
            state_nxt = S_DONE;
          end else begin
            idx_nxt = idx_inc;
          end
        end else begin
          div_start = 1'b1;
          state_nxt = S_DIV_WAIT;
        end
      end

      S_DIV_WAIT: begin
        if (div_done) begin
          tbl_we   = 1'b1;
          tbl_wtkt = TktW'(div_quotient);
          if (last_entry) begin
            state_nxt = S_DONE;
          end else begin
            idx_nxt   = idx_inc;
            state_nxt = S_DIV_GO;
          end
        end
      end

      // cumulative walk, first entry whose running sum reaches the draw wins
      S_DRAW: begin
        total_nxt = run_sum;
        if (TotW'(draw_r) <= run_sum) begin
          res_status_nxt = StOk;
          res_winner_nxt = id_table[idx_r[IdxW-1:0]];
          state_nxt      = S_DONE;
        end else if (last_entry) begin
          res_status_nxt = StNoWinner;
          state_nxt      = S_DONE;
        end else begin
          idx_nxt = idx_inc;
        end
      end

      // hand the result to the output register once it is free
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_winner_nxt = res_winner_r;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    idx_r        <= idx_nxt;
    total_r      <= total_nxt;
    draw_r       <= draw_nxt;
    res_status_r <= res_status_nxt;
    res_winner_r <= res_winner_nxt;
    out_status_r <= out_status_nxt;
    out_winner_r <= out_winner_nxt;
  end

  // table writes
  always_ff @(posedge clk) begin
    if (tbl_we) begin
      ticket_table[tbl_waddr] <= tbl_wtkt;
    end
    if (tbl_id_we) begin
      id_table[tbl_waddr] <= in_process_id;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_winner_id = out_winner_r;

  // entry count never runs past the table size
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CntW'(MaxProcs))
    else $error("entry count beyond table size");

  // an accepted add on a table with room grows the count by one
  a_add_grows: assert property (@(posedge clk) disable iff (!rst_n)
    in_beat && in_req_type == ReqAdd && count_r != CntW'(MaxProcs)
    |=> count_r == $past(count_r) + CntW'(1))
    else $error("add beat did not grow the table");

  // only a successful draw reports a nonzero winner
  a_winner_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_status_r != StOk |-> out_winner_r == '0)
    else $error("winner id set on a failed beat");

  // the divider only delivers a result in the wait state of the normalize pass
  a_div_scope: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == S_DIV_WAIT)
    else $error("divider result outside normalize pass");

endmodule : lottery_scheduler_select

`default_nettype wire

// File: test/lottery_select_checker.sv
// lottery_select_checker: watches both channels of lottery_scheduler_select,
// predicts each result from its own copy of the table and compares field by field
// depends on lss_pkg for widths, request and status codes
`timescale 1ns / 1ps

module lottery_select_checker import lss_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_stall,
  input  logic [ReqW-1:0]  in_req_type,
  input  logic [IdW-1:0]   in_process_id,
  input  logic [TktW-1:0]  in_ticket_count,
  input  logic [DrawW-1:0] in_draw_value,
  input  logic             out_valid,
  input  logic             out_stall,
  input  logic [StatW-1:0] out_status,
  input  logic [IdW-1:0]   out_winner_id,
  output int               mismatches,
  output int               outstanding
);

  typedef struct packed {
    logic [StatW-1:0] status;
    logic [IdW-1:0]   winner;
  } outcome_t;

  // shadow of the scheduler table
  logic [IdW-1:0]  pid_tbl   [MaxProcs];
  logic [TktW-1:0] share_tbl [MaxProcs];
  int              used_entries;

  outcome_t expected_outcomes[$];

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t ns: %s", $time, what);
    mismatches++;
  endtask

  function automatic outcome_t predict_outcome(input logic [ReqW-1:0]  req,
                                               input logic [IdW-1:0]   pid,
                                               input logic [TktW-1:0]  tkt,
                                               input logic [DrawW-1:0] draw);
    outcome_t    res;
    logic [31:0] total;
    logic [31:0] running;
    bit          found;
    res.status = StOk;
    res.winner = '0;
    total      = '0;
    running    = '0;
    found      = 1'b0;
    case (req)
      ReqAdd: begin
        if (used_entries >= MaxProcs) begin
          res.status = StFull;
        end else begin
          pid_tbl[used_entries]   = pid;
          share_tbl[used_entries] = tkt;
          used_entries++;
        end
      end
      ReqNorm: begin
        for (int i = 0; i < used_entries; i++) total += 32'(share_tbl[i]);
        for (int i = 0; i < used_entries; i++) begin
          if (total == 0) share_tbl[i] = '0;
          else share_tbl[i] = TktW'((32'(share_tbl[i]) * 32'(Scale)) / total);
        end
      end
      ReqDraw: begin
        for (int i = 0; i < used_entries; i++) begin
          if (!found) begin
            running += 32'(share_tbl[i]);
            if (32'(draw) <= running) begin
              found      = 1'b1;
              res.winner = pid_tbl[i];
            end
          end
        end
        if (!found) res.status = StNoWinner;
      end
      default: ;
    endcase
    return res;
  endfunction

  always @(posedge clk) begin
    outcome_t want;
    if (!rst_n) begin
      used_entries = 0;
      expected_outcomes.delete();
      mismatches   = 0;
      outstanding  = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_outcomes.size() == 0) begin
          report_mismatch("result beat with nothing expected");
        end else begin
          want = expected_outcomes.pop_front();
          if (out_status !== want.status)
            report_mismatch($sformatf("status %0d, expected %0d", out_status, want.status));
          if (out_winner_id !== want.winner)
            report_mismatch($sformatf("winner_id %h, expected %h", out_winner_id, want.winner));
        end
      end
      if (in_valid && !in_stall) begin
        expected_outcomes = {expected_outcomes,
                             predict_outcome(in_req_type, in_process_id,
                                             in_ticket_count, in_draw_value)};
      end
      outstanding = expected_outcomes.size();
    end
  end

endmodule

// File: test/tb_lottery_scheduler_select.sv
// tb_lottery_scheduler_select: stimulus, handshake pacing and verdict for the lottery scheduler
// depends on lss_pkg, lottery_scheduler_select and lottery_select_checker
`timescale 1ns / 1ps

module tb_lottery_scheduler_select import lss_pkg::*;;

  // run sizing
  localparam int RandomItems = 850;
  localparam int CycleLimit  = 1000000;
  localparam int DrainCycles = 200;      // longer than one normalize over a full table
  localparam int PauseItem   = 500;      // sender waits for every result here
  localparam int HoldBeat    = 300;      // receiver holds off here
  localparam int HoldCycles  = 300;

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_stall;
  logic [ReqW-1:0]  in_req_type;
  logic [IdW-1:0]   in_process_id;
  logic [TktW-1:0]  in_ticket_count;
  logic [DrawW-1:0] in_draw_value;
  logic             out_valid;
  logic             out_stall;
  logic [StatW-1:0] out_status;
  logic [IdW-1:0]   out_winner_id;

  int mismatches;
  int outstanding;
  int cycle_count;
  int adds_sent;
  int item_index;

  lottery_scheduler_select u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_req_type     (in_req_type),
    .in_process_id   (in_process_id),
    .in_ticket_count (in_ticket_count),
    .in_draw_value   (in_draw_value),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_winner_id   (out_winner_id)
  );

  lottery_select_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_req_type     (in_req_type),
    .in_process_id   (in_process_id),
    .in_ticket_count (in_ticket_count),
    .in_draw_value   (in_draw_value),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_winner_id   (out_winner_id),
    .mismatches      (mismatches),
    .outstanding     (outstanding)
  );

  // 10 ns clock
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // watchdog: a hung handshake or a lost result ends here
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  // offer one beat after a random gap, hold it until the block takes it
  // gaps vanish in the first 40 items of every 200 so back-to-back traffic shows up too
  task automatic send_beat(input logic [ReqW-1:0]  req,
                           input logic [IdW-1:0]   pid,
                           input logic [TktW-1:0]  tkt,
                           input logic [DrawW-1:0] draw);
    int gap;
    gap = ((item_index % 200) < 40) ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_req_type     <= req;
    in_process_id   <= pid;
    in_ticket_count <= tkt;
    in_draw_value   <= draw;
    do @(posedge clk); while (in_stall);
    if (req == ReqAdd) adds_sent++;
    item_index++;
  endtask

  // ticket counts: mostly small so that draws land across several entries,
  // some full range and some at the extremes
  function automatic logic [TktW-1:0] pick_tickets();
    case ($urandom_range(0, 3))
      0:       return TktW'($urandom_range(0, 30));
      1:       return TktW'($urandom_range(0, 200));
      2:       return TktW'($urandom_range(0, 65535));
      default: return $urandom_range(0, 1) ? '1 : '0;
    endcase
  endfunction

  // draw values: mostly the legal 1 to 100, now and then zero or above 100
  function automatic logic [DrawW-1:0] pick_draw();
    if ($urandom_range(0, 15) == 0) return DrawW'($urandom_range(0, 127));
    return DrawW'($urandom_range(1, 100));
  endfunction

  // one random request; adds are spread out so the table fills slowly and
  // draws see many partly filled tables, both raw and normalized
  task automatic send_random_beat();
    int          pick;
    logic [ReqW-1:0] req;
    pick = $urandom_range(0, 99);
    if (pick < 14)      req = ReqAdd;
    else if (pick < 26) req = ReqNorm;
    else if (pick < 29) req = ReqNone;
    else                req = ReqDraw;
    send_beat(req, IdW'($urandom_range(0, 65535)), pick_tickets(), pick_draw());
  endtask

  // stimulus
  initial begin
    rst_n           <= 1'b0;
    in_valid        <= 1'b0;
    in_req_type     <= ReqNone;
    in_process_id   <= '0;
    in_ticket_count <= '0;
    in_draw_value   <= '0;
    adds_sent  = 0;
    item_index = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty table: draw finds no winner, normalize sees a zero total
    send_beat(ReqDraw, 16'h1234, 16'h4321, 7'd50);
    send_beat(ReqNorm, 16'hFFFF, 16'hFFFF, 7'h7F);
    // unused request code changes nothing
    send_beat(ReqNone, 16'hFFFF, 16'hFFFF, 7'h7F);
    send_beat(ReqNone, 16'h0000, 16'h0000, 7'h00);
    // lowest id and zero tickets: draw of zero still picks the first entry
    send_beat(ReqAdd,  16'h0000, 16'h0000, 7'h00);
    send_beat(ReqDraw, 16'hFFFF, 16'hFFFF, 7'd0);
    send_beat(ReqDraw, 16'h0000, 16'h0000, 7'd1);
    // zero total with entries present
    send_beat(ReqNorm, 16'h0000, 16'h0000, 7'd0);
    // highest id and tickets; draw before normalize walks raw counts,
    // draw above 100 follows the same rule
    send_beat(ReqAdd,  16'hFFFF, 16'hFFFF, 7'h7F);
    send_beat(ReqDraw, 16'h0000, 16'h0000, 7'h7F);
    send_beat(ReqAdd,  16'h5A5A, 16'h0001, 7'd0);
    // shares become 0, 99, 0: truncation leaves a draw of 100 uncovered
    send_beat(ReqNorm, 16'hA5A5, 16'h5A5A, 7'h55);
    send_beat(ReqDraw, 16'h0000, 16'h0000, 7'd100);
    send_beat(ReqDraw, 16'h0000, 16'h0000, 7'd99);
    send_beat(ReqDraw, 16'h0000, 16'h0000, 7'd1);
    send_beat(ReqAdd,  16'hA5A5, 16'h0001, 7'd0);
    send_beat(ReqDraw, 16'h0000, 16'h0000, 7'd100);
    send_beat(ReqDraw, 16'h0000, 16'h0000, 7'd101);

    item_index = 0;
    for (int n = 0; n < RandomItems; n++) begin
      send_random_beat();
      // sender pause: let the block and the result side run dry
      if (n == PauseItem) begin
        in_valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
      end
    end

    // make sure the full-table case is seen, then draw and normalize on a full table
    while (adds_sent <= MaxProcs)
      send_beat(ReqAdd, IdW'($urandom_range(0, 65535)), pick_tickets(), pick_draw());
    send_beat(ReqDraw, 16'h0000, 16'h0000, 7'd100);
    send_beat(ReqNorm, 16'h0000, 16'h0000, 7'd0);
    send_beat(ReqDraw, 16'h0000, 16'h0000, 7'd100);

    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    // extra cycles catch any stray result beat
    repeat (DrainCycles) @(posedge clk);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // result side: random hold-off before each beat, a gap-free window every
  // 200 beats, and one long hold so the block backs up into its input
  initial begin
    int beats;
    int gap;
    out_stall <= 1'b0;
    beats = 0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (beats == HoldBeat) gap = HoldCycles;
      else if ((beats % 200) >= 100 && (beats % 200) < 140) gap = 0;
      else gap = $urandom_range(0, 9);
      if (gap > 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      beats++;
    end
  end

endmodule
